// File: design/dpst_pkg.sv
// Shared types and constants for the dynamic prefix-sum table.
package dpst_pkg;

  localparam int CAPACITY   = 256;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int POS_W      = IDX_W + 1;
  localparam int ANSWER_W   = 40;
  localparam int TARGET_W   = 40;
  localparam int ACC_W      = VALUE_BITS + IDX_W;

  typedef enum logic [2:0] {
    OP_READ   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_INSERT = 3'd2,
    OP_ADD    = 3'd3,
    OP_SUB    = 3'd4,
    OP_PREFIX = 3'd5,
    OP_FIND   = 3'd6,
    OP_CLEAR  = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_BADPOS = 3'd1,
    ST_FULL   = 3'd2,
    ST_OVER   = 3'd3,
    ST_UNDER  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_RUN  = 2'd1,
    S_DONE = 2'd2
  } state_t;

  // Request broadcast to every cell; stable while a sweep runs.
  typedef struct packed {
    op_t                   op;
    logic [POS_W-1:0]      pos;
    logic [VALUE_BITS-1:0] operand;
    logic [TARGET_W-1:0]   target;
    logic [POS_W-1:0]      count;
    logic                  act;
  } cmd_t;

  // Sweep token handed from cell to cell.
  typedef struct packed {
    logic                  tok;
    logic [ACC_W-1:0]      acc;
    logic [VALUE_BITS-1:0] carry;
    logic                  found;
    logic [ANSWER_W-1:0]   ans;
    status_t               st;
  } wave_t;

endpackage

// File: design/dpst_cell.sv
// One table cell: holds one entry and processes the sweep token as it passes.
module dpst_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [dpst_pkg::IDX_W-1:0]      idx,
  input  dpst_pkg::cmd_t                  cmd,
  input  dpst_pkg::wave_t                 w_in,
  output dpst_pkg::wave_t                 w_out
);

  logic [dpst_pkg::VALUE_BITS-1:0] val_r, val_nxt;
  dpst_pkg::wave_t                 w_r, w_nxt;
  logic [dpst_pkg::POS_W-1:0]      idx_x;
  logic                            hit, below, live;
  logic [dpst_pkg::VALUE_BITS:0]   sum;
  logic [dpst_pkg::ACC_W-1:0]      acc_n;

  assign idx_x  = {1'b0, idx};
  assign hit    = (idx_x == cmd.pos);
  assign below  = (idx_x < cmd.pos);
  assign live   = (idx_x < cmd.count);
  assign sum    = {1'b0, val_r} + {1'b0, cmd.operand};
  assign acc_n  = w_in.acc + dpst_pkg::ACC_W'(val_r);

  always_comb begin
    val_nxt = val_r;
    w_nxt   = w_in;
    if (w_in.tok && cmd.act) begin
      case (cmd.op)
        dpst_pkg::OP_READ: begin
          if (hit) w_nxt.ans = dpst_pkg::ANSWER_W'(val_r);
        end
        dpst_pkg::OP_WRITE: begin
          if (hit) val_nxt = cmd.operand;
        end
        dpst_pkg::OP_INSERT: begin
          // entries at or above the slot move up by one
          if (!below) begin
            val_nxt     = w_in.carry;
            w_nxt.carry = val_r;
          end
        end
        dpst_pkg::OP_ADD: begin
          if (hit) begin
            if (sum[dpst_pkg::VALUE_BITS]) begin
              val_nxt  = '1;
              w_nxt.st = dpst_pkg::ST_OVER;
            end else begin
              val_nxt = sum[dpst_pkg::VALUE_BITS-1:0];
            end
            w_nxt.ans = dpst_pkg::ANSWER_W'(val_nxt);
          end
        end
        dpst_pkg::OP_SUB: begin
          if (hit) begin
            if (cmd.operand > val_r) begin
              val_nxt  = '0;
              w_nxt.st = dpst_pkg::ST_UNDER;
            end else begin
              val_nxt = val_r - cmd.operand;
            end
            w_nxt.ans = dpst_pkg::ANSWER_W'(val_nxt);
          end
        end
        dpst_pkg::OP_PREFIX: begin
          if (below) w_nxt.acc = acc_n;
        end
        dpst_pkg::OP_FIND: begin
          if (live && !w_in.found) begin
            w_nxt.acc = acc_n;
            if (dpst_pkg::TARGET_W'(acc_n) > cmd.target) begin
              w_nxt.found = 1'b1;
              w_nxt.ans   = dpst_pkg::ANSWER_W'(idx);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (!rst_n) begin
      w_r <= '0;
    end else begin
      w_r <= w_nxt;
    end
  end

  assign w_out = w_r;

endmodule

// File: design/dynamic_prefix_sum_table.sv
// Top level of the dynamic prefix-sum table: request control and the cell chain.
//
// The table keeps an ordered list of up to 256 unsigned 32-bit entries in a
// chain of 256 cells, one entry per cell. Every request (read, write, insert,
// add, subtract, prefix sum, find, clear) launches a token that walks the chain
// one cell per clock; each cell acts on its own entry as the token passes, so
// inserts shift entries up cell to cell and sums build up along the way. A
// request is launched through a register, its token walks all 256 cells and
// the result is loaded into an output register once that register is free.
// The next request is taken only after that, with one request in flight at
// a time. The result sits in an output register, so a new request is taken
// while the previous result still waits; only a result still unread when the
// next walk finishes holds things up. Add and subtract saturate and flag
// status 3 or 4; an insert into a full table gives status 2; a bad position
// gives status 1 and leaves the table untouched.
module dynamic_prefix_sum_table (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [2:0]                      in_op,
  input  logic [dpst_pkg::POS_W-1:0]      in_position,
  input  logic [dpst_pkg::VALUE_BITS-1:0] in_operand,
  input  logic [dpst_pkg::TARGET_W-1:0]   in_target_sum,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dpst_pkg::ANSWER_W-1:0]   out_answer,
  output logic [2:0]                      out_status,
  output logic [dpst_pkg::POS_W-1:0]      out_entry_count
);

  dpst_pkg::state_t state_r, state_nxt;
  dpst_pkg::op_t    op_r;
  dpst_pkg::op_t    in_op_t;
  logic [dpst_pkg::POS_W-1:0]      pos_r, count_r, count_nxt;
  logic [dpst_pkg::VALUE_BITS-1:0] operand_r;
  logic [dpst_pkg::TARGET_W-1:0]   target_r;
  logic                            act_r, act_nxt;
  dpst_pkg::status_t               pre_st_r, pre_st_nxt;
  logic                            launch_r;
  dpst_pkg::wave_t                 fin_r;
  logic                            out_valid_r;
  logic [dpst_pkg::ANSWER_W-1:0]   ans_r, ans_nxt;
  dpst_pkg::status_t               st_r, st_nxt;
  logic [dpst_pkg::POS_W-1:0]      cnt_out_r;

  logic                            accept, slot_free, load_out;
  dpst_pkg::cmd_t                  cmd;
  dpst_pkg::wave_t                 chain [0:dpst_pkg::CAPACITY];
  logic [dpst_pkg::CAPACITY-1:0]   tok_vec;

  assign in_op_t   = dpst_pkg::op_t'(in_op);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // Entry checks done up front against the current count.
  always_comb begin
    pre_st_nxt = dpst_pkg::ST_OK;
    case (in_op_t)
      dpst_pkg::OP_READ, dpst_pkg::OP_WRITE, dpst_pkg::OP_ADD, dpst_pkg::OP_SUB: begin
        if (in_position >= count_r) pre_st_nxt = dpst_pkg::ST_BADPOS;
      end
      dpst_pkg::OP_INSERT: begin
        if (count_r == dpst_pkg::POS_W'(dpst_pkg::CAPACITY)) pre_st_nxt = dpst_pkg::ST_FULL;
        else if (in_position > count_r)                      pre_st_nxt = dpst_pkg::ST_BADPOS;
      end
      dpst_pkg::OP_PREFIX: begin
        if (in_position > count_r) pre_st_nxt = dpst_pkg::ST_BADPOS;
      end
      default: ;
    endcase
    act_nxt = (pre_st_nxt == dpst_pkg::ST_OK);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dpst_pkg::S_IDLE: if (accept) state_nxt = dpst_pkg::S_RUN;
      dpst_pkg::S_RUN:  if (chain[dpst_pkg::CAPACITY].tok) state_nxt = dpst_pkg::S_DONE;
      dpst_pkg::S_DONE: if (slot_free) state_nxt = dpst_pkg::S_IDLE;
      default:          state_nxt = dpst_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    case (state_r)
      dpst_pkg::S_IDLE: in_ready = 1'b1;
      dpst_pkg::S_DONE: load_out = slot_free;
      default: ;
    endcase
  end

  // Result assembly from the token that left the last cell.
  always_comb begin
    ans_nxt   = '0;
    st_nxt    = pre_st_r;
    count_nxt = count_r;
    if (act_r) begin
      case (op_r)
        dpst_pkg::OP_READ:  ans_nxt = fin_r.ans;
        dpst_pkg::OP_WRITE: ans_nxt = dpst_pkg::ANSWER_W'(operand_r);
        dpst_pkg::OP_INSERT: begin
          ans_nxt   = dpst_pkg::ANSWER_W'(operand_r);
          count_nxt = count_r + 1'b1;
        end
        dpst_pkg::OP_ADD, dpst_pkg::OP_SUB: begin
          ans_nxt = fin_r.ans;
          st_nxt  = fin_r.st;
        end
        // 256 entries of 32 bits cannot exceed the 40-bit answer
        dpst_pkg::OP_PREFIX: ans_nxt = dpst_pkg::ANSWER_W'(fin_r.acc);
        dpst_pkg::OP_FIND: begin
          if (fin_r.found) begin
            ans_nxt = fin_r.ans;
          end else begin
            ans_nxt = dpst_pkg::ANSWER_W'(count_r);
            st_nxt  = dpst_pkg::ST_BADPOS;
          end
        end
        dpst_pkg::OP_CLEAR: count_nxt = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dpst_pkg::S_IDLE;
      count_r     <= '0;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= accept;
      if (load_out) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= in_op_t;
      pos_r     <= in_position;
      operand_r <= in_operand;
      target_r  <= in_target_sum;
      act_r     <= act_nxt;
      pre_st_r  <= pre_st_nxt;
    end
    if (chain[dpst_pkg::CAPACITY].tok) fin_r <= chain[dpst_pkg::CAPACITY];
    if (load_out) begin
      ans_r     <= ans_nxt;
      st_r      <= st_nxt;
      cnt_out_r <= count_nxt;
    end
  end

  assign cmd.op      = op_r;
  assign cmd.pos     = pos_r;
  assign cmd.operand = operand_r;
  assign cmd.target  = target_r;
  assign cmd.count   = count_r;
  assign cmd.act     = act_r;

  // Token enters cell 0 the cycle after acceptance, carrying the insert value.
  assign chain[0].tok   = launch_r;
  assign chain[0].acc   = '0;
  assign chain[0].carry = operand_r;
  assign chain[0].found = 1'b0;
  assign chain[0].ans   = '0;
  assign chain[0].st    = dpst_pkg::ST_OK;

  for (genvar g = 0; g < dpst_pkg::CAPACITY; g++) begin : g_cell
    dpst_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .idx   (dpst_pkg::IDX_W'(g)),
      .cmd   (cmd),
      .w_in  (chain[g]),
      .w_out (chain[g+1])
    );
    assign tok_vec[g] = chain[g+1].tok;
  end

  assign out_valid       = out_valid_r;
  assign out_answer      = ans_r;
  assign out_status      = st_r;
  assign out_entry_count = cnt_out_r;

  // Only one token may walk the chain.
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec)) else $error("more than one token in chain");

  // Tokens live only while a request is running.
  a_tok_run: assert property (@(posedge clk) disable iff (!rst_n)
    (|tok_vec) |-> (state_r == dpst_pkg::S_RUN)) else $error("token outside run");

  // Entry count never passes capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= dpst_pkg::POS_W'(dpst_pkg::CAPACITY)) else $error("count over capacity");

endmodule

// File: bench/dpst_checker.sv
`timescale 1ns / 1ps
// Transaction monitor, table predictor and result comparator for the prefix-sum table.
module dpst_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [2:0]                      in_op,
  input  logic [dpst_pkg::POS_W-1:0]      in_position,
  input  logic [dpst_pkg::VALUE_BITS-1:0] in_operand,
  input  logic [dpst_pkg::TARGET_W-1:0]   in_target_sum,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [dpst_pkg::ANSWER_W-1:0]   out_answer,
  input  logic [2:0]                      out_status,
  input  logic [dpst_pkg::POS_W-1:0]      out_entry_count,
  output int                              fail_count,
  output int                              pending
);

  typedef struct packed {
    logic [dpst_pkg::ANSWER_W-1:0] answer;
    dpst_pkg::status_t             status;
    logic [dpst_pkg::POS_W-1:0]    cnt;
  } table_result_t;

  logic [dpst_pkg::VALUE_BITS-1:0] table_vals [dpst_pkg::CAPACITY];
  int unsigned                     table_len;
  table_result_t                   result_q [$];

  function automatic table_result_t apply_request(dpst_pkg::op_t op, int unsigned pos,
                                                  logic [dpst_pkg::VALUE_BITS-1:0] val,
                                                  logic [dpst_pkg::TARGET_W-1:0] tgt);
    table_result_t r;
    logic [63:0]   acc;
    int unsigned   k;
    r.answer = '0;
    r.status = dpst_pkg::ST_OK;
    case (op)
      dpst_pkg::OP_READ: begin
        if (pos < table_len) r.answer = dpst_pkg::ANSWER_W'(table_vals[pos]);
        else r.status = dpst_pkg::ST_BADPOS;
      end
      dpst_pkg::OP_WRITE: begin
        if (pos < table_len) begin
          table_vals[pos] = val;
          r.answer = dpst_pkg::ANSWER_W'(val);
        end else r.status = dpst_pkg::ST_BADPOS;
      end
      dpst_pkg::OP_INSERT: begin
        if (table_len >= dpst_pkg::CAPACITY) r.status = dpst_pkg::ST_FULL;
        else if (pos > table_len) r.status = dpst_pkg::ST_BADPOS;
        else begin
          for (k = table_len; k > pos; k--) table_vals[k] = table_vals[k-1];
          table_vals[pos] = val;
          r.answer = dpst_pkg::ANSWER_W'(val);
          table_len++;
        end
      end
      dpst_pkg::OP_ADD: begin
        if (pos < table_len) begin
          acc = 64'(table_vals[pos]) + 64'(val);
          if (acc > 64'hFFFF_FFFF) begin
            acc = 64'hFFFF_FFFF;
            r.status = dpst_pkg::ST_OVER;
          end
          table_vals[pos] = acc[dpst_pkg::VALUE_BITS-1:0];
          r.answer = dpst_pkg::ANSWER_W'(table_vals[pos]);
        end else r.status = dpst_pkg::ST_BADPOS;
      end
      dpst_pkg::OP_SUB: begin
        if (pos < table_len) begin
          if (val > table_vals[pos]) begin
            table_vals[pos] = '0;
            r.status = dpst_pkg::ST_UNDER;
          end else table_vals[pos] = table_vals[pos] - val;
          r.answer = dpst_pkg::ANSWER_W'(table_vals[pos]);
        end else r.status = dpst_pkg::ST_BADPOS;
      end
      dpst_pkg::OP_PREFIX: begin
        if (pos <= table_len) begin
          acc = '0;
          for (k = 0; k < pos; k++) acc += 64'(table_vals[k]);
          r.answer = acc[dpst_pkg::ANSWER_W-1:0];
        end else r.status = dpst_pkg::ST_BADPOS;
      end
      dpst_pkg::OP_FIND: begin
        acc = '0;
        r.status = dpst_pkg::ST_BADPOS;
        for (k = 0; k < table_len; k++) begin
          acc += 64'(table_vals[k]);
          if (acc > 64'(tgt)) begin
            r.status = dpst_pkg::ST_OK;
            break;
          end
        end
        r.answer = dpst_pkg::ANSWER_W'(k);
      end
      default: table_len = 0;
    endcase
    r.cnt = dpst_pkg::POS_W'(table_len);
    return r;
  endfunction

  assign pending = result_q.size();

  always @(posedge clk) begin
    table_result_t want;
    int            errs;
    errs = 0;
    if (!rst_n) begin
      table_len = 0;
      fail_count <= 0;
      result_q.delete();
    end else begin
      if (in_valid && in_ready)
        result_q.push_back(apply_request(dpst_pkg::op_t'(in_op), in_position, in_operand,
                                         in_target_sum));
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("unexpected result transaction");
          errs++;
        end else begin
          want = result_q.pop_front();
          if (out_answer !== want.answer) begin
            $error("answer: expected %0h, got %0h", want.answer, out_answer);
            errs++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            errs++;
          end
          if (out_entry_count !== want.cnt) begin
            $error("entry_count: expected %0d, got %0d", want.cnt, out_entry_count);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

// File: bench/tb_dynamic_prefix_sum_table.sv
`timescale 1ns / 1ps
// Stimulus, idling and verdict for the dynamic prefix-sum table.
module tb_dynamic_prefix_sum_table;

  // Each request occupies the block for a whole walk of the chain; the idle watchdog
  // allows several of those plus the longest idle draws.
  localparam int LATENCY = dpst_pkg::CAPACITY + 3;
  localparam int IDLE_LIMIT = 8 * LATENCY + 100;
  localparam int RANDOM_ITEMS = 520;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [2:0]                      in_op = dpst_pkg::OP_READ;
  logic [dpst_pkg::POS_W-1:0]      in_position = '0;
  logic [dpst_pkg::VALUE_BITS-1:0] in_operand = '0;
  logic [dpst_pkg::TARGET_W-1:0]   in_target_sum = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [dpst_pkg::ANSWER_W-1:0]   out_answer;
  logic [2:0]                      out_status;
  logic [dpst_pkg::POS_W-1:0]      out_entry_count;
  int                              fail_count;
  int                              pending;
  int                              idle_cycles = 0;
  int                              sent = 0;
  int                              inserts = 0;
  bit                              stim_done = 1'b0;
  int unsigned                     shadow_len = 0;  // rough length tracker to aim positions

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  dynamic_prefix_sum_table dut (.*);

  dpst_checker u_checker (.*);

  // Watchdog: cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: random stall before each result, sometimes none at all.
  initial begin
    int gap;
    wait (rst_n);
    forever begin
      @(negedge clk);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // One transaction: optional idle gap, then hold valid until accepted.
  task automatic send_request(dpst_pkg::op_t op, int unsigned pos,
                              logic [dpst_pkg::VALUE_BITS-1:0] val,
                              logic [dpst_pkg::TARGET_W-1:0] tgt, int gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_op         <= op;
    in_position   <= pos[dpst_pkg::POS_W-1:0];
    in_operand    <= val;
    in_target_sum <= tgt;
    in_valid      <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
    case (op)
      dpst_pkg::OP_INSERT: if (shadow_len < dpst_pkg::CAPACITY && pos <= shadow_len) begin
        shadow_len++;
        inserts++;
      end
      dpst_pkg::OP_CLEAR: shadow_len = 0;
      default: ;
    endcase
  endtask

  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic logic [dpst_pkg::VALUE_BITS-1:0] draw_value();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    dpst_pkg::op_t                 op;
    int unsigned                   pos;
    logic [dpst_pkg::TARGET_W-1:0] tgt;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty-table cases, extremes, each op, saturation.
    send_request(dpst_pkg::OP_FIND, 0, '0, '0, 0);                  // find on empty table
    send_request(dpst_pkg::OP_READ, 0, '0, '0, 0);                  // read beyond count
    send_request(dpst_pkg::OP_INSERT, 1, 5, '0, 0);                 // insert past end
    send_request(dpst_pkg::OP_INSERT, 0, '1, '0, 0);
    send_request(dpst_pkg::OP_INSERT, 0, 32'h0000_0001, '0, 0);
    send_request(dpst_pkg::OP_INSERT, 2, 32'h8000_0000, '0, 1);
    send_request(dpst_pkg::OP_ADD, 1, 32'h1, '0, 0);                // overflow saturates
    send_request(dpst_pkg::OP_SUB, 0, 32'h2, '0, 0);                // underflow to zero
    send_request(dpst_pkg::OP_WRITE, 0, 32'h5555_5555, '0, 0);
    send_request(dpst_pkg::OP_SUB, 0, 32'h1111_1111, '0, 2);
    send_request(dpst_pkg::OP_ADD, 2, 32'h7FFF_FFFF, '0, 0);
    send_request(dpst_pkg::OP_READ, 2, '0, '0, 0);
    send_request(dpst_pkg::OP_PREFIX, 3, '0, '0, 0);
    send_request(dpst_pkg::OP_PREFIX, 0, '0, '0, 0);
    send_request(dpst_pkg::OP_PREFIX, 4, '0, '0, 0);                // bad position
    send_request(dpst_pkg::OP_WRITE, 3, 1, '0, 0);                  // bad position
    send_request(dpst_pkg::OP_FIND, 0, '0, '0, 0);
    send_request(dpst_pkg::OP_FIND, 0, '0, {dpst_pkg::TARGET_W{1'b1}}, 0);  // no match
    send_request(dpst_pkg::OP_FIND, 0, '0, 40'h1_0000_0000, 3);
    send_request(dpst_pkg::OP_READ, 9'h1FF, '0, '0, 0);             // top position bits
    send_request(dpst_pkg::OP_CLEAR, 0, '0, '0, 0);
    send_request(dpst_pkg::OP_ADD, 0, 1, '0, 0);

    // Fill to capacity, then an insert into the full table.
    while (shadow_len < dpst_pkg::CAPACITY)
      send_request(dpst_pkg::OP_INSERT, $urandom_range(0, shadow_len), draw_value(), '0, 0);
    send_request(dpst_pkg::OP_INSERT, 0, 32'h1234_5678, '0, 0);     // table full
    send_request(dpst_pkg::OP_PREFIX, dpst_pkg::CAPACITY, '0, '0, 0);
    send_request(dpst_pkg::OP_READ, dpst_pkg::CAPACITY - 1, '0, '0, 0);
    send_request(dpst_pkg::OP_FIND, 0, '0, 40'hFF_FFFF_FFFF, 0);

    // Hold off until every expected result is back.
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    send_request(dpst_pkg::OP_CLEAR, 0, '0, '0, 0);

    // Random: mostly valid positions, with a slice out of range.
    repeat (RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: op = dpst_pkg::OP_INSERT;
        6, 7:             op = dpst_pkg::OP_READ;
        8, 9:             op = dpst_pkg::OP_WRITE;
        10, 11:           op = dpst_pkg::OP_ADD;
        12, 13:           op = dpst_pkg::OP_SUB;
        14, 15:           op = dpst_pkg::OP_PREFIX;
        16, 17, 18:       op = dpst_pkg::OP_FIND;
        default:          op = ($urandom_range(0, 3) == 0) ? dpst_pkg::OP_CLEAR
                                                           : dpst_pkg::OP_READ;
      endcase
      if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, 511);
      else pos = $urandom_range(0, shadow_len);
      tgt = dpst_pkg::TARGET_W'({$urandom(), $urandom()});
      if ($urandom_range(0, 1))
        tgt = dpst_pkg::TARGET_W'(64'(tgt) % (64'(shadow_len) * 64'h8000_0000 + 1));
      send_request(op, pos, draw_value(), tgt, ($urandom_range(0, 4) == 0) ? 0 : draw_gap());
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 20) @(negedge clk);
    $display("covered %0d requests (%0d accepted inserts) across all ops,", sent, inserts);
    $display("including full table, saturation and out-of-range positions");
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
